/* rtl/wsp_pkg.sv */
// Shared constants, types and register codes of the world-to-screen projection block.
package wsp_pkg;

    localparam int COORD_BITS     = 32;
    localparam int FRAC_BITS      = 16;
    localparam int COEF_BITS      = 32;
    localparam int SIZE_BITS      = 14;
    localparam int NUM_ROWS       = 3;
    localparam int NUM_COLS       = 4;
    localparam int NUM_PAIRS      = 6;
    localparam int CFG_INDEX_BITS = 4;
    localparam int CFG_DATA_BITS  = 64;

    localparam int PROD_BITS  = COEF_BITS + COORD_BITS;
    localparam int SUM_BITS   = PROD_BITS + 2;
    localparam int CLIP_BITS  = SUM_BITS - FRAC_BITS;
    localparam int REM_BITS   = CLIP_BITS;
    localparam int SCALE_BITS = CLIP_BITS + SIZE_BITS;
    localparam int NUM_BITS   = SCALE_BITS + FRAC_BITS + 1;
    localparam int OUT_SPAN   = (COORD_BITS > SIZE_BITS + FRAC_BITS) ?
                                COORD_BITS : SIZE_BITS + FRAC_BITS;
    localparam int QUO_BITS   = OUT_SPAN + 3;
    localparam int RES_BITS   = QUO_BITS + 2;
    localparam int FRONT_STAGES = 7;

    localparam int BEHIND_GAIN = 100000;
    localparam int GAIN_BITS   = 18;
    localparam int SMALL_BITS  = COORD_BITS - 16;
    localparam longint OUT_MAX    = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint OUT_MIN    = -OUT_MAX - 1;
    localparam longint BEHIND_LIM = OUT_MAX / BEHIND_GAIN;
    localparam int THR_RAW   = ((2 ** FRAC_BITS) + 500) / 1000;
    localparam int THRESHOLD = (THR_RAW < 1) ? 1 : THR_RAW;

    localparam logic signed [CLIP_BITS-1:0]  LIM_POS  = CLIP_BITS'(BEHIND_LIM);
    localparam logic signed [CLIP_BITS-1:0]  LIM_NEG  = CLIP_BITS'(-BEHIND_LIM);
    localparam logic signed [CLIP_BITS-1:0]  THRESH_W = CLIP_BITS'(THRESHOLD);
    localparam logic signed [COORD_BITS-1:0] SAT_MAX  = COORD_BITS'(OUT_MAX);
    localparam logic signed [COORD_BITS-1:0] SAT_MIN  = COORD_BITS'(OUT_MIN);

    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(longint'(1) <<< FRAC_BITS);
    localparam logic [CFG_DATA_BITS-1:0] ROW0_A_RESET = {COEF_ONE, {COEF_BITS{1'b0}}};
    localparam logic [CFG_DATA_BITS-1:0] ROW1_A_RESET = {{COEF_BITS{1'b0}}, COEF_ONE};
    localparam logic [CFG_DATA_BITS-1:0] ROW3_B_RESET = {{COEF_BITS{1'b0}}, COEF_ONE};
    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = SIZE_BITS'(640);
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = SIZE_BITS'(480);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ROW0_A = 4'd0,
        REG_ROW0_B = 4'd1,
        REG_ROW1_A = 4'd2,
        REG_ROW1_B = 4'd3,
        REG_ROW3_A = 4'd4,
        REG_ROW3_B = 4'd5,
        REG_WIDTH  = 4'd6,
        REG_HEIGHT = 4'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_ROWS-1:0][NUM_COLS-1:0][COEF_BITS-1:0] coef;
        logic [SIZE_BITS-1:0] width;
        logic [SIZE_BITS-1:0] height;
    } proj_cfg_t;

    typedef struct packed {
        logic [REM_BITS-1:0] rem;
        logic [QUO_BITS-1:0] low;
    } div_lane_t;

    typedef struct packed {
        logic                         visible;
        logic                         neg_x;
        logic                         neg_y;
        logic                         ovf_x;
        logic                         ovf_y;
        logic signed [COORD_BITS-1:0] behind_x;
        logic signed [COORD_BITS-1:0] behind_y;
    } side_t;

endpackage

/* rtl/wsp_front.sv */
// Front pipeline: matrix products, clip sums, visibility test and divider setup.
module wsp_front import wsp_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic signed [COORD_BITS-1:0] in_z,
    input  proj_cfg_t                    cfg,
    output logic                         out_valid,
    output logic [REM_BITS-1:0]          out_w,
    output div_lane_t                    out_x,
    output div_lane_t                    out_y,
    output side_t                        out_side
);

    function automatic logic signed [PROD_BITS-1:0] smul(
        input logic signed [COEF_BITS-1:0]  a,
        input logic signed [COORD_BITS-1:0] b
    );
        logic signed [PROD_BITS-1:0] ae;
        logic signed [PROD_BITS-1:0] be;
        ae = PROD_BITS'(a);
        be = PROD_BITS'(b);
        return ae * be;
    endfunction

    logic [FRONT_STAGES-1:0] valid_reg;

    logic signed [COORD_BITS-1:0] pt [3];
    logic signed [PROD_BITS-1:0]  prod_reg [NUM_ROWS][3];
    logic signed [SUM_BITS-1:0]   part_a_reg [NUM_ROWS];
    logic signed [SUM_BITS-1:0]   part_b_reg [NUM_ROWS];
    logic signed [SUM_BITS-1:0]   sum [NUM_ROWS];
    logic signed [CLIP_BITS-1:0]  clip_reg [NUM_ROWS];

    logic signed [CLIP_BITS-1:0]  w4_reg, w5_reg, w6_reg;
    logic                         vis4_reg, vis5_reg, vis6_reg;
    logic                         neg4_reg [2];
    logic                         neg5_reg [2];
    logic                         neg6_reg [2];
    logic [CLIP_BITS-1:0]         mag4_reg [2];
    logic                         hi4_reg [2];
    logic                         lo4_reg [2];
    logic signed [SMALL_BITS-1:0] small4_reg [2];
    logic [SCALE_BITS-1:0]        scale5_reg [2];
    logic signed [COORD_BITS-1:0] behind5_reg [2];
    logic signed [COORD_BITS-1:0] behind6_reg [2];
    logic [NUM_BITS-1:0]          num6_reg [2];
    logic signed [COORD_BITS+1:0] gain_prod [2];
    logic [SIZE_BITS-1:0]         size_sel [2];
    logic [NUM_BITS-QUO_BITS-1:0] head [2];

    assign pt[0] = in_x;
    assign pt[1] = in_y;
    assign pt[2] = in_z;
    assign size_sel[0] = cfg.width;
    assign size_sel[1] = cfg.height;

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            sum[r] = part_a_reg[r] + part_b_reg[r];
        end
        for (int a = 0; a < 2; a++) begin
            gain_prod[a] = (COORD_BITS+2)'(small4_reg[a]) *
                           (COORD_BITS+2)'($signed(GAIN_BITS'(BEHIND_GAIN)));
            head[a] = num6_reg[a][NUM_BITS-1:QUO_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[FRONT_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[r][c] <= smul($signed(cfg.coef[r][c]), pt[c]);
                end
                part_a_reg[r] <= SUM_BITS'(prod_reg[r][0]) + SUM_BITS'(prod_reg[r][1]);
                part_b_reg[r] <= SUM_BITS'(prod_reg[r][2]) +
                    SUM_BITS'($signed({cfg.coef[r][3], 1'b1, {(FRAC_BITS-1){1'b0}}}));
                clip_reg[r] <= sum[r][SUM_BITS-1:FRAC_BITS];
            end

            w4_reg   <= clip_reg[2];
            vis4_reg <= clip_reg[2] >= THRESH_W;
            w5_reg   <= w4_reg;
            vis5_reg <= vis4_reg;
            w6_reg   <= w5_reg;
            vis6_reg <= vis5_reg;

            for (int a = 0; a < 2; a++) begin
                neg4_reg[a]   <= clip_reg[a][CLIP_BITS-1];
                mag4_reg[a]   <= clip_reg[a][CLIP_BITS-1] ? CLIP_BITS'(-clip_reg[a])
                                                          : clip_reg[a];
                hi4_reg[a]    <= clip_reg[a] > LIM_POS;
                lo4_reg[a]    <= clip_reg[a] < LIM_NEG;
                small4_reg[a] <= clip_reg[a][SMALL_BITS-1:0];

                neg5_reg[a]   <= neg4_reg[a];
                scale5_reg[a] <= SCALE_BITS'(mag4_reg[a]) * SCALE_BITS'(size_sel[a]);
                if (hi4_reg[a]) begin
                    behind5_reg[a] <= SAT_MAX;
                end else if (lo4_reg[a]) begin
                    behind5_reg[a] <= SAT_MIN;
                end else begin
                    behind5_reg[a] <= gain_prod[a][COORD_BITS-1:0];
                end

                neg6_reg[a]    <= neg5_reg[a];
                behind6_reg[a] <= behind5_reg[a];
                num6_reg[a]    <= {1'b0, scale5_reg[a], {FRAC_BITS{1'b0}}} +
                                  NUM_BITS'(unsigned'(w5_reg));
            end

            out_w            <= unsigned'(w6_reg);
            out_x.rem        <= REM_BITS'(head[0]);
            out_x.low        <= num6_reg[0][QUO_BITS-1:0];
            out_y.rem        <= REM_BITS'(head[1]);
            out_y.low        <= num6_reg[1][QUO_BITS-1:0];
            out_side.visible <= vis6_reg;
            out_side.neg_x   <= neg6_reg[0];
            out_side.neg_y   <= neg6_reg[1];
            out_side.ovf_x   <= REM_BITS'(head[0]) >= unsigned'(w6_reg);
            out_side.ovf_y   <= REM_BITS'(head[1]) >= unsigned'(w6_reg);
            out_side.behind_x <= behind6_reg[0];
            out_side.behind_y <= behind6_reg[1];
        end
    end

    assign out_valid = valid_reg[FRONT_STAGES-1];

endmodule

/* rtl/wsp_div_stage.sv */
// One restoring division step for the x and y pixel offsets, with its pipeline register.
module wsp_div_stage import wsp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [REM_BITS-1:0] in_w,
    input  div_lane_t           in_x,
    input  div_lane_t           in_y,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [REM_BITS-1:0] out_w,
    output div_lane_t           out_x,
    output div_lane_t           out_y,
    output side_t               out_side
);

    function automatic div_lane_t step(input div_lane_t lane, input logic [REM_BITS-1:0] w);
        logic [REM_BITS-1:0] shifted;
        logic                ge;
        div_lane_t           res;
        shifted = {lane.rem[REM_BITS-2:0], lane.low[QUO_BITS-1]};
        ge      = shifted >= w;
        res.rem = ge ? shifted - w : shifted;
        res.low = {lane.low[QUO_BITS-2:0], ge};
        return res;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_w    <= in_w;
            out_x    <= step(in_x, in_w);
            out_y    <= step(in_y, in_w);
            out_side <= in_side;
        end
    end

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(out_valid))
        else $error("Division stage valid changed during a stall.");
    a_rem_x: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_side.visible && !out_side.ovf_x |-> out_x.rem < out_w)
        else $error("X partial remainder is not below the divisor.");
    a_rem_y: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_side.visible && !out_side.ovf_y |-> out_y.rem < out_w)
        else $error("Y partial remainder is not below the divisor.");
`endif

endmodule

/* rtl/wsp_out.sv */
// Output stage: pixel mapping, saturation, behind-viewer select and result register.
module wsp_out import wsp_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  div_lane_t                    in_x,
    input  div_lane_t                    in_y,
    input  side_t                        in_side,
    input  logic [SIZE_BITS-1:0]         width,
    input  logic [SIZE_BITS-1:0]         height,
    output logic                         m_valid,
    output logic signed [COORD_BITS-1:0] m_screen_x,
    output logic signed [COORD_BITS-1:0] m_screen_y,
    output logic                         m_visible
);

    localparam logic [QUO_BITS-1:0] CAP = QUO_BITS'(1) << (QUO_BITS - 1);
    localparam logic signed [RES_BITS-1:0] HALF = RES_BITS'(1) <<< (FRAC_BITS - 1);

    function automatic logic signed [COORD_BITS-1:0] pixel(
        input logic [QUO_BITS-1:0]  q,
        input logic                 ovf,
        input logic                 neg,
        input logic [SIZE_BITS-1:0] size,
        input logic                 is_y
    );
        logic [QUO_BITS-1:0]        m;
        logic signed [RES_BITS-1:0] off;
        logic signed [RES_BITS-1:0] base;
        logic signed [RES_BITS-1:0] r;
        m    = ovf ? CAP : {1'b0, q[QUO_BITS-1:1]};
        off  = neg ? -$signed(RES_BITS'(m)) : $signed(RES_BITS'(m));
        base = $signed(RES_BITS'({size[SIZE_BITS-1:1], {FRAC_BITS{1'b0}}}));
        r    = is_y ? base - off - HALF : base + off + HALF;
        if (r > RES_BITS'(SAT_MAX)) begin
            return SAT_MAX;
        end else if (r < RES_BITS'(SAT_MIN)) begin
            return SAT_MIN;
        end
        return r[COORD_BITS-1:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (en) begin
            m_valid <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_visible <= in_side.visible;
            if (in_side.visible) begin
                m_screen_x <= pixel(in_x.low, in_side.ovf_x, in_side.neg_x, width, 1'b0);
                m_screen_y <= pixel(in_y.low, in_side.ovf_y, in_side.neg_y, height, 1'b1);
            end else begin
                m_screen_x <= in_side.behind_x;
                m_screen_y <= in_side.behind_y;
            end
        end
    end

endmodule

/* rtl/world_to_screen_projection.sv */
// Top level of the world-to-screen projection block: configuration registers and pipeline.
//
// A point (s_point_x/y/z, signed Q16.16) is taken on the s_ channel with valid and ready;
// the projected pixel position and the visible flag leave on the m_ channel.
// Clip x, y and w come from matrix rows 0, 1 and 3; points with w below 0.001 are
// reported as not visible with x and y scaled by 100000 and saturated.
// The configuration port writes one register per cycle while cfg_wr_en is high:
// indexes 0 to 5 hold the coefficient pairs, 6 the width, 7 the height; others are ignored.
// The user must write registers only while no point is in flight; the block does not enforce it.
// Throughput is one point per clock while m_ready does not stall the pipeline. A point
// passes seven front stages, one stage per quotient bit of the 35-step divider, and
// the output register on its way from the input transfer to m_valid.
// Synchronous active-low reset clears all valid bits and loads the identity matrix and a
// 640 by 480 viewport.
// The whole pipeline advances together; while a result waits on m_ready the pipeline
// holds and s_ready is low, so nothing is lost or repeated.
module world_to_screen_projection import wsp_pkg::*; (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_wr_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_point_x,
    input  logic signed [COORD_BITS-1:0] s_point_y,
    input  logic signed [COORD_BITS-1:0] s_point_z,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [COORD_BITS-1:0] m_screen_x,
    output logic signed [COORD_BITS-1:0] m_screen_y,
    output logic                         m_visible
);

    logic [CFG_DATA_BITS-1:0] pair_reg [NUM_PAIRS];
    logic [SIZE_BITS-1:0]     width_reg;
    logic [SIZE_BITS-1:0]     height_reg;
    proj_cfg_t                cfg;
    logic                     en;

    logic                stg_valid [QUO_BITS+1];
    logic [REM_BITS-1:0] stg_w     [QUO_BITS+1];
    div_lane_t           stg_x     [QUO_BITS+1];
    div_lane_t           stg_y     [QUO_BITS+1];
    side_t               stg_side  [QUO_BITS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pair_reg[0] <= ROW0_A_RESET;
            pair_reg[1] <= '0;
            pair_reg[2] <= ROW1_A_RESET;
            pair_reg[3] <= '0;
            pair_reg[4] <= '0;
            pair_reg[5] <= ROW3_B_RESET;
            width_reg   <= WIDTH_RESET;
            height_reg  <= HEIGHT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_ROW0_A: begin
                    pair_reg[0] <= cfg_wr_data;
                end
                REG_ROW0_B: begin
                    pair_reg[1] <= cfg_wr_data;
                end
                REG_ROW1_A: begin
                    pair_reg[2] <= cfg_wr_data;
                end
                REG_ROW1_B: begin
                    pair_reg[3] <= cfg_wr_data;
                end
                REG_ROW3_A: begin
                    pair_reg[4] <= cfg_wr_data;
                end
                REG_ROW3_B: begin
                    pair_reg[5] <= cfg_wr_data;
                end
                REG_WIDTH: begin
                    width_reg <= cfg_wr_data[SIZE_BITS-1:0];
                end
                REG_HEIGHT: begin
                    height_reg <= cfg_wr_data[SIZE_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            cfg.coef[r][0] = pair_reg[2*r][CFG_DATA_BITS-1:COEF_BITS];
            cfg.coef[r][1] = pair_reg[2*r][COEF_BITS-1:0];
            cfg.coef[r][2] = pair_reg[2*r+1][CFG_DATA_BITS-1:COEF_BITS];
            cfg.coef[r][3] = pair_reg[2*r+1][COEF_BITS-1:0];
        end
        cfg.width  = width_reg;
        cfg.height = height_reg;
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    wsp_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_x      (s_point_x),
        .in_y      (s_point_y),
        .in_z      (s_point_z),
        .cfg       (cfg),
        .out_valid (stg_valid[0]),
        .out_w     (stg_w[0]),
        .out_x     (stg_x[0]),
        .out_y     (stg_y[0]),
        .out_side  (stg_side[0])
    );

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
        wsp_div_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (stg_valid[k]),
            .in_w      (stg_w[k]),
            .in_x      (stg_x[k]),
            .in_y      (stg_y[k]),
            .in_side   (stg_side[k]),
            .out_valid (stg_valid[k+1]),
            .out_w     (stg_w[k+1]),
            .out_x     (stg_x[k+1]),
            .out_y     (stg_y[k+1]),
            .out_side  (stg_side[k+1])
        );
    end

    wsp_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (stg_valid[QUO_BITS]),
        .in_x       (stg_x[QUO_BITS]),
        .in_y       (stg_y[QUO_BITS]),
        .in_side    (stg_side[QUO_BITS]),
        .width      (width_reg),
        .height     (height_reg),
        .m_valid    (m_valid),
        .m_screen_x (m_screen_x),
        .m_screen_y (m_screen_y),
        .m_visible  (m_visible)
    );

endmodule

/* sim/world_to_screen_projection_test.sv */
// Self-checking testbench for the world-to-screen projection block with its own projection predictor.
module world_to_screen_projection_test;
    import wsp_pkg::*;

    typedef struct {
        logic signed [COORD_BITS-1:0] sx;
        logic signed [COORD_BITS-1:0] sy;
        logic                         vis;
    } screen_pt_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
    } world_pt_t;

    localparam logic [CFG_INDEX_BITS-1:0] UNUSED_INDEX = 4'hF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 60;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_wr_data = '0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [COORD_BITS-1:0] s_point_x = '0;
    logic signed [COORD_BITS-1:0] s_point_y = '0;
    logic signed [COORD_BITS-1:0] s_point_z = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [COORD_BITS-1:0] m_screen_x;
    logic signed [COORD_BITS-1:0] m_screen_y;
    logic                         m_visible;

    logic [CFG_DATA_BITS-1:0] proj_regs [8];
    world_pt_t  pending_points[$];
    screen_pt_t expected_pixels[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    int  points_queued = 0;
    int  points_taken = 0;
    int  pixels_checked = 0;
    int  hidden_seen = 0;
    int  errors = 0;
    int  cycle_count = 0;
    logic point_taken = 1'b0;

    world_to_screen_projection i_dut (.*);

    always #5 aclk = ~aclk;

    function automatic longint clip_row(int row, world_pt_t p);
        logic signed [127:0] acc;
        longint c [4];
        logic [CFG_DATA_BITS-1:0] r;
        for (int col = 0; col < 4; col++) begin
            r = proj_regs[row * 2 + col / 2];
            c[col] = (col % 2) ? longint'($signed(r[31:0])) : longint'($signed(r[63:32]));
        end
        acc = c[0] * longint'(p.x) + c[1] * longint'(p.y) + c[2] * longint'(p.z)
            + c[3] * longint'(1 <<< FRAC_BITS) + longint'(1 <<< (FRAC_BITS - 1));
        acc = acc >>> FRAC_BITS;
        if (acc > 128'sh7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
        if (acc < -128'sh8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
        return longint'(acc);
    endfunction

    function automatic longint pixel_offset(longint c, longint w, logic [SIZE_BITS-1:0] size);
        logic [127:0] n;
        logic [127:0] q;
        logic [63:0]  m;
        m = (c < 0) ? 64'(-c) : 64'(c);
        n = 128'(m) * (128'(size) << FRAC_BITS);
        q = (n + 128'(w)) / 128'(w);
        q = q >> 1;
        m = (q > (128'd1 << 62)) ? (64'd1 << 62) : q[63:0];
        return (c < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_out(longint v);
        if (v > OUT_MAX) return OUT_MAX;
        if (v < OUT_MIN) return OUT_MIN;
        return v;
    endfunction

    function automatic longint behind_scale(longint v);
        if (v > BEHIND_LIM) return OUT_MAX;
        if (v < -BEHIND_LIM) return OUT_MIN;
        return v * BEHIND_GAIN;
    endfunction

    function automatic screen_pt_t project_point(world_pt_t p);
        screen_pt_t res;
        longint cx, cy, cw;
        logic [SIZE_BITS-1:0] wd, ht;
        cx = clip_row(0, p);
        cy = clip_row(1, p);
        cw = clip_row(2, p);
        wd = proj_regs[REG_WIDTH][SIZE_BITS-1:0];
        ht = proj_regs[REG_HEIGHT][SIZE_BITS-1:0];
        if (cw < THRESHOLD) begin
            res.sx = COORD_BITS'(behind_scale(cx));
            res.sy = COORD_BITS'(behind_scale(cy));
            res.vis = 1'b0;
        end else begin
            res.sx = COORD_BITS'(clamp_out((longint'(wd >> 1) <<< FRAC_BITS)
                     + pixel_offset(cx, cw, wd) + longint'(1 <<< (FRAC_BITS - 1))));
            res.sy = COORD_BITS'(clamp_out((longint'(ht >> 1) <<< FRAC_BITS)
                     - (pixel_offset(cy, cw, ht) + longint'(1 <<< (FRAC_BITS - 1)))));
            res.vis = 1'b1;
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_coef();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
        if (pick < 8) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h0;
            1: return COEF_ONE;
            2: return 32'h8000_0000;
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic signed [31:0] rand_coord(bit positive);
        if ($urandom_range(0, 9) < 3) return $urandom;
        if (positive) return 32'($urandom_range(1, 1 << 22));
        return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
    endfunction

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= data;
        if (idx < 8) begin
            proj_regs[idx] = (idx >= REG_WIDTH) ? data & 64'h3FFF : data;
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic random_matrix();
        for (int i = REG_ROW0_A; i <= REG_ROW3_B; i++) begin
            write_reg(CFG_INDEX_BITS'(i), {rand_coef(), rand_coef()});
        end
    endtask

    task automatic add_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic signed [31:0] z);
        world_pt_t p;
        p.x = x;
        p.y = y;
        p.z = z;
        pending_points.push_back(p);
        points_queued++;
    endtask

    task automatic add_random(int count);
        for (int i = 0; i < count; i++) begin
            add_point(rand_coord(0), rand_coord(0), rand_coord($urandom_range(0, 9) < 8));
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk);
        while (points_taken != points_queued || expected_pixels.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || point_taken)) begin
            if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_point_x <= pending_points[0].x;
                s_point_y <= pending_points[0].y;
                s_point_z <= pending_points[0].z;
                void'(pending_points.pop_front());
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        world_pt_t  p;
        screen_pt_t e;
        point_taken = s_valid && s_ready && aresetn;
        if (point_taken) begin
            p.x = s_point_x;
            p.y = s_point_y;
            p.z = s_point_z;
            expected_pixels.push_back(project_point(p));
            points_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: result with no pending expectation: x %h y %h vis %b",
                         $time, m_screen_x, m_screen_y, m_visible);
                errors++;
            end else begin
                e = expected_pixels.pop_front();
                if (e.sx !== m_screen_x) begin
                    $display("%0t: screen_x expected %h actual %h", $time, e.sx, m_screen_x);
                    errors++;
                end
                if (e.sy !== m_screen_y) begin
                    $display("%0t: screen_y expected %h actual %h", $time, e.sy, m_screen_y);
                    errors++;
                end
                if (e.vis !== m_visible) begin
                    $display("%0t: visible expected %b actual %b", $time, e.vis, m_visible);
                    errors++;
                end
                if (!e.vis) hidden_seen++;
                pixels_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, expected_pixels.size());
            $display("world_to_screen_projection verification failed");
            $finish;
        end
    end

    initial begin
        proj_regs[REG_ROW0_A] = ROW0_A_RESET;
        proj_regs[REG_ROW0_B] = '0;
        proj_regs[REG_ROW1_A] = ROW1_A_RESET;
        proj_regs[REG_ROW1_B] = '0;
        proj_regs[REG_ROW3_A] = '0;
        proj_regs[REG_ROW3_B] = ROW3_B_RESET;
        proj_regs[REG_WIDTH]  = 64'(WIDTH_RESET);
        proj_regs[REG_HEIGHT] = 64'(HEIGHT_RESET);
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Reset matrix, extremes of every coordinate.
        add_point(0, 0, 0);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, 0);
        add_point(32'h0001_0000, -32'sh0001_0000, 32'h0001_0000);
        add_point(32'hFFFF_FFFF, 32'h0000_8000, -1);
        add_random(290);
        wait_idle();

        // Perspective divide by z, covering the behind-viewer threshold.
        write_reg(REG_ROW3_A, '0);
        write_reg(REG_ROW3_B, {COEF_ONE, 32'h0});
        write_reg(REG_ROW0_B, '0);
        write_reg(REG_ROW1_B, '0);
        add_point(32'h0001_0000, 32'h0001_0000, 0);
        add_point(32'h0001_0000, 32'h0001_0000, THRESHOLD - 1);
        add_point(32'h0001_0000, -32'sh0001_0000, THRESHOLD);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, THRESHOLD);
        add_point(32'h7FFF_FFFF, 32'h8000_0000, -32'sh0001_0000);
        add_point(32'h0000_5000, -32'sh0000_5000, -32'sh0001_0000);
        add_point(32'h0000_5400, -32'sh0000_5400, 32'h8000_0000);
        add_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_point(1, -1, 32'h7FFF_FFFF);
        send_idle_pct = 86;
        add_random(290);
        wait_idle();

        // Random matrix at a viewport width of 8192 and a height of 1.
        random_matrix();
        write_reg(REG_WIDTH, 64'd8192);
        write_reg(REG_HEIGHT, 64'd1);
        send_idle_pct = 0;
        recv_stall_pct = 86;
        add_random(300);
        wait_idle();

        // Zero and full-scale viewport sizes.
        random_matrix();
        write_reg(REG_WIDTH, 64'd0);
        write_reg(REG_HEIGHT, 64'h3FFF);
        send_idle_pct = 24;
        recv_stall_pct = 24;
        add_random(150);
        wait_idle();
        write_reg(REG_WIDTH, 64'h3FFF);
        write_reg(REG_HEIGHT, 64'd0);
        add_random(150);
        wait_idle();

        // Long receiver hold-off while the sender keeps offering points.
        write_reg(REG_ROW0_A, {COEF_ONE, 32'h0});
        write_reg(REG_ROW1_A, {32'h0, COEF_ONE});
        write_reg(REG_ROW3_A, '0);
        write_reg(REG_ROW3_B, {COEF_ONE, 32'h0001_0000});
        write_reg(REG_WIDTH, 64'd1920);
        write_reg(REG_HEIGHT, 64'd1080);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_requests++;
        add_random(300);
        wait_idle();

        // A write to an unused index must leave the configuration alone.
        write_reg(UNUSED_INDEX, {rand_coef(), rand_coef()});
        random_matrix();
        write_reg(REG_WIDTH, 64'($urandom_range(1, 8192)));
        write_reg(REG_HEIGHT, 64'($urandom_range(1, 8192)));
        send_idle_pct = 24;
        recv_stall_pct = 86;
        add_random(150);
        wait_idle();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        add_random(150);
        wait_idle();

        if (expected_pixels.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_pixels.size());
            errors++;
        end
        $display("Checked %0d projected points (%0d behind the viewer) over seven settings,",
                 pixels_checked, hidden_seen);
        $display("including idle, stall and long hold-off phases; %0d mismatches.", errors);
        if (errors == 0) begin
            $display("world_to_screen_projection verification clean");
        end else begin
            $display("world_to_screen_projection verification failed");
        end
        $finish;
    end
endmodule
